@@ design/assert_macros.svh @@
// Assertion macros used by the crop-box filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RTCB_ASSERT_HOLDS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("Assertion failed.");
`define RTCB_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("Assertion failed.");
`else
`define RTCB_ASSERT_HOLDS(lbl, clk, rst, prop)
`define RTCB_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

@@ design/rtcb_pkg.sv @@
package rtcb_pkg;

   localparam int COORD_WIDTH_DEF    = 32;
   localparam int QUAT_FRAC_BITS_DEF = 14;
   localparam int QUAT_WIDTH         = 16;
   localparam int BOX_SIDE_RESET     = 16384;
   localparam int Z_FLOOR_DIV        = 50;

   typedef enum logic [2:0] {
      CSR_ROT_W    = 3'd0,
      CSR_ROT_X    = 3'd1,
      CSR_ROT_Y    = 3'd2,
      CSR_ROT_Z    = 3'd3,
      CSR_SHIFT_X  = 3'd4,
      CSR_SHIFT_Y  = 3'd5,
      CSR_SHIFT_Z  = 3'd6,
      CSR_BOX_SIDE = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
   } stage_en_type;

   function automatic int rot_width(input int frac_bits);
      return ((2 * frac_bits > 32) ? 2 * frac_bits : 32) + 2;
   endfunction

   function automatic int prod_width(input int coord_width, input int frac_bits);
      return rot_width(frac_bits) + coord_width;
   endfunction

   function automatic int sum_width(input int coord_width, input int frac_bits);
      return prod_width(coord_width, frac_bits) + 2;
   endfunction

endpackage

@@ design/rtcb_if.sv @@
interface rtcb_point_if #(
   parameter int COORD_WIDTH = rtcb_pkg::COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   logic signed [COORD_WIDTH-1:0] point_z;
   logic                          cloud_end;

   modport source (output valid, point_x, point_y, point_z, cloud_end, input ready);
   modport sink (input valid, point_x, point_y, point_z, cloud_end, output ready);
endinterface

interface rtcb_kept_if #(
   parameter int COORD_WIDTH = rtcb_pkg::COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] kept_x;
   logic signed [COORD_WIDTH-1:0] kept_y;
   logic signed [COORD_WIDTH-1:0] kept_z;
   logic                          kept_end;

   modport source (output valid, kept_x, kept_y, kept_z, kept_end, input ready);
   modport sink (input valid, kept_x, kept_y, kept_z, kept_end, output ready);
endinterface

@@ design/rtcb_row.sv @@
module rtcb_row #(
   parameter int COORD_WIDTH    = rtcb_pkg::COORD_WIDTH_DEF,
   parameter int QUAT_FRAC_BITS = rtcb_pkg::QUAT_FRAC_BITS_DEF,
   localparam int RW = rtcb_pkg::rot_width(QUAT_FRAC_BITS),
   localparam int PW = rtcb_pkg::prod_width(COORD_WIDTH, QUAT_FRAC_BITS),
   localparam int QW = rtcb_pkg::sum_width(COORD_WIDTH, QUAT_FRAC_BITS)
) (
   input  logic                          clock,
   input  rtcb_pkg::stage_en_type        en,
   input  logic signed [RW-1:0]          coef [3],
   input  logic signed [COORD_WIDTH-1:0] pnt [3],
   input  logic signed [COORD_WIDTH-1:0] shift,
   output logic signed [QW-1:0]          row_sum
);

   logic signed [PW-1:0] prod_ff [3];
   logic signed [PW-1:0] prod_in [3];
   logic signed [QW-1:0] part_a_ff, part_b_ff, sum_ff;
   logic signed [QW-1:0] shift_scaled;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         prod_in[j] = PW'(coef[j]) * PW'(pnt[j]);
      end
      shift_scaled = QW'(shift) <<< (2 * QUAT_FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         for (int j = 0; j < 3; j++) begin
            prod_ff[j] <= prod_in[j];
         end
      end
      if (en.s3) begin
         part_a_ff <= QW'(prod_ff[0]) + QW'(prod_ff[1]);
         part_b_ff <= QW'(prod_ff[2]) + shift_scaled;
      end
      if (en.s4) begin
         sum_ff <= part_a_ff + part_b_ff;
      end
   end

   assign row_sum = sum_ff;

endmodule

@@ design/rigid_transform_crop_box_filter.sv @@
// Crop-box filter on a point stream. Each point is rotated by the configured
// quaternion and translated, and it is passed on unchanged, with its end mark, only
// if the moved point lies inside the box; other points are dropped and give no item.
// One point is accepted every cycle while the output keeps up. A point passes six
// registers: input register, multiplier stage, two adder stages, compare stage and
// output register, before its item is offered. While the output is held, the points
// behind a kept point wait; a dropped point never waits for the output. Configuration
// writes take effect for points accepted from the cycle after the write.
`include "assert_macros.svh"

module rigid_transform_crop_box_filter #(
   parameter int COORD_WIDTH    = rtcb_pkg::COORD_WIDTH_DEF,
   parameter int QUAT_FRAC_BITS = rtcb_pkg::QUAT_FRAC_BITS_DEF,
   localparam int CSR_DW = (COORD_WIDTH > 32) ? 64 : 32,
   localparam int CSR_AW = (COORD_WIDTH > 32) ? 6 : 5
) (
   input  logic              clock,
   input  logic              reset,
   rtcb_point_if.sink        req_ch,
   rtcb_kept_if.source       rsp_ch,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   localparam int CW = COORD_WIDTH;
   localparam int F  = QUAT_FRAC_BITS;
   localparam int QBW = rtcb_pkg::QUAT_WIDTH;
   localparam int RW = rtcb_pkg::rot_width(F);
   localparam int QW = rtcb_pkg::sum_width(CW, F);
   localparam logic [QBW-1:0] ROT_W_RESET = QBW'(64'(1) << F);
   localparam logic signed [RW-1:0] ONE = RW'(1) <<< (2 * F);
   localparam logic [QW-1:0] Z_FLOOR_MAG = (QW'(1) << (16 + 2 * F)) / rtcb_pkg::Z_FLOOR_DIV;
   localparam logic signed [QW-1:0] Z_FLOOR = -$signed(Z_FLOOR_MAG);

   logic signed [QBW-1:0] rot_w_ff, rot_x_ff, rot_y_ff, rot_z_ff;
   logic signed [CW-1:0]  shift_ff [3];
   logic [CW-2:0]         box_side_ff;
   logic                  csr_write;
   rtcb_pkg::csr_index_type csr_idx;

   logic signed [2*QBW-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
   logic signed [RW-1:0]    coef_in [3][3];
   logic signed [RW-1:0]    coef_ff [3][3];

   logic [5:1]            v_ff;
   logic [5:1]            rdy;
   logic signed [CW-1:0]  pt_ff [1:5][3];
   logic                  end_ff [1:5];
   logic                  keep_ff, keep_in;
   logic                  kept_at_end;
   logic                  out_free;
   logic                  rsp_valid_ff;
   logic signed [CW-1:0]  kept_ff [3];
   logic                  kept_end_ff;
   rtcb_pkg::stage_en_type stage_en;
   logic signed [QW-1:0]  row_sum [3];
   logic signed [QW-1:0]  lim_half, lim_full;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_idx   = rtcb_pkg::csr_index_type'(paddr[CSR_AW-1 -: 3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_w_ff    <= ROT_W_RESET;
         rot_x_ff    <= '0;
         rot_y_ff    <= '0;
         rot_z_ff    <= '0;
         shift_ff[0] <= '0;
         shift_ff[1] <= '0;
         shift_ff[2] <= '0;
         box_side_ff <= (CW-1)'(rtcb_pkg::BOX_SIDE_RESET);
      end else if (csr_write) begin
         unique case (csr_idx)
            rtcb_pkg::CSR_ROT_W: begin
               rot_w_ff <= pwdata[QBW-1:0];
            end
            rtcb_pkg::CSR_ROT_X: begin
               rot_x_ff <= pwdata[QBW-1:0];
            end
            rtcb_pkg::CSR_ROT_Y: begin
               rot_y_ff <= pwdata[QBW-1:0];
            end
            rtcb_pkg::CSR_ROT_Z: begin
               rot_z_ff <= pwdata[QBW-1:0];
            end
            rtcb_pkg::CSR_SHIFT_X: begin
               shift_ff[0] <= pwdata[CW-1:0];
            end
            rtcb_pkg::CSR_SHIFT_Y: begin
               shift_ff[1] <= pwdata[CW-1:0];
            end
            rtcb_pkg::CSR_SHIFT_Z: begin
               shift_ff[2] <= pwdata[CW-1:0];
            end
            rtcb_pkg::CSR_BOX_SIDE: begin
               box_side_ff <= pwdata[CW-2:0];
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         rtcb_pkg::CSR_ROT_W:    prdata = CSR_DW'(unsigned'(rot_w_ff));
         rtcb_pkg::CSR_ROT_X:    prdata = CSR_DW'(unsigned'(rot_x_ff));
         rtcb_pkg::CSR_ROT_Y:    prdata = CSR_DW'(unsigned'(rot_y_ff));
         rtcb_pkg::CSR_ROT_Z:    prdata = CSR_DW'(unsigned'(rot_z_ff));
         rtcb_pkg::CSR_SHIFT_X:  prdata = CSR_DW'(unsigned'(shift_ff[0]));
         rtcb_pkg::CSR_SHIFT_Y:  prdata = CSR_DW'(unsigned'(shift_ff[1]));
         rtcb_pkg::CSR_SHIFT_Z:  prdata = CSR_DW'(unsigned'(shift_ff[2]));
         rtcb_pkg::CSR_BOX_SIDE: prdata = CSR_DW'(box_side_ff);
      endcase
   end

   // The rotation matrix is rebuilt from the quaternion every cycle.
   always_comb begin
      xx = rot_x_ff * rot_x_ff;
      yy = rot_y_ff * rot_y_ff;
      zz = rot_z_ff * rot_z_ff;
      xy = rot_x_ff * rot_y_ff;
      xz = rot_x_ff * rot_z_ff;
      yz = rot_y_ff * rot_z_ff;
      wx = rot_w_ff * rot_x_ff;
      wy = rot_w_ff * rot_y_ff;
      wz = rot_w_ff * rot_z_ff;
      coef_in[0][0] = ONE - ((RW'(yy) + RW'(zz)) <<< 1);
      coef_in[0][1] = (RW'(xy) - RW'(wz)) <<< 1;
      coef_in[0][2] = (RW'(xz) + RW'(wy)) <<< 1;
      coef_in[1][0] = (RW'(xy) + RW'(wz)) <<< 1;
      coef_in[1][1] = ONE - ((RW'(xx) + RW'(zz)) <<< 1);
      coef_in[1][2] = (RW'(yz) - RW'(wx)) <<< 1;
      coef_in[2][0] = (RW'(xz) - RW'(wy)) <<< 1;
      coef_in[2][1] = (RW'(yz) + RW'(wx)) <<< 1;
      coef_in[2][2] = ONE - ((RW'(xx) + RW'(yy)) <<< 1);
   end

   always_ff @(posedge clock) begin
      coef_ff <= coef_in;
   end

   assign out_free    = !rsp_valid_ff || rsp_ch.ready;
   assign kept_at_end = v_ff[5] && keep_ff;

   // A stage takes new data when it is empty or its content moves on; a dropped
   // point leaves the compare stage without needing the output register.
   always_comb begin
      rdy[5] = !v_ff[5] || !keep_ff || out_free;
      for (int i = 4; i >= 1; i--) begin
         rdy[i] = !v_ff[i] || rdy[i+1];
      end
   end

   assign req_ch.ready = rdy[1];
   assign stage_en.s2  = rdy[2];
   assign stage_en.s3  = rdy[3];
   assign stage_en.s4  = rdy[4];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         keep_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy[1]) begin
            v_ff[1] <= req_ch.valid;
         end
         for (int i = 2; i <= 5; i++) begin
            if (rdy[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
         if (rdy[5]) begin
            keep_ff <= keep_in;
         end
         if (out_free) begin
            rsp_valid_ff <= v_ff[5] && keep_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         pt_ff[1][0] <= req_ch.point_x;
         pt_ff[1][1] <= req_ch.point_y;
         pt_ff[1][2] <= req_ch.point_z;
         end_ff[1]   <= req_ch.cloud_end;
      end
      for (int i = 2; i <= 5; i++) begin
         if (rdy[i]) begin
            pt_ff[i]  <= pt_ff[i-1];
            end_ff[i] <= end_ff[i-1];
         end
      end
      if (out_free) begin
         kept_ff     <= pt_ff[5];
         kept_end_ff <= end_ff[5];
      end
   end

   for (genvar r = 0; r < 3; r++) begin : g_row
      rtcb_row #(
         .COORD_WIDTH    (COORD_WIDTH),
         .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
      ) u_row (
         .clock   (clock),
         .en      (stage_en),
         .coef    (coef_ff[r]),
         .pnt     (pt_ff[1]),
         .shift   (shift_ff[r]),
         .row_sum (row_sum[r])
      );
   end

   // The box tests are done on the moved point at full scale, so no bit is lost.
   always_comb begin
      lim_half = QW'(box_side_ff) <<< (2 * F - 1);
      lim_full = QW'(box_side_ff) <<< (2 * F);
      keep_in  = (row_sum[0] >= -lim_half) && (row_sum[0] <= lim_half) &&
                 (row_sum[1] >= -lim_half) && (row_sum[1] <= lim_half) &&
                 (row_sum[2] <= lim_full) && (row_sum[2] >= Z_FLOOR);
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.kept_x   = kept_ff[0];
   assign rsp_ch.kept_y   = kept_ff[1];
   assign rsp_ch.kept_z   = kept_ff[2];
   assign rsp_ch.kept_end = kept_end_ff;

   `RTCB_ASSERT_NEXT(a_kept_reaches_out, clock, reset, out_free && kept_at_end, rsp_valid_ff)
   `RTCB_ASSERT_NEXT(a_no_invented_item, clock, reset, out_free && !kept_at_end, !rsp_valid_ff)
   `RTCB_ASSERT_HOLDS(a_full_stall, clock, reset, req_ch.ready || (&v_ff && kept_at_end && !out_free))

endmodule

@@ dv/tb_top.sv @@
module tb_top;

   localparam int CW = rtcb_pkg::COORD_WIDTH_DEF;
   localparam int QF = rtcb_pkg::QUAT_FRAC_BITS_DEF;
   localparam int DRAIN_CYCLES = 16;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int RANDOM_ITEMS = 1300;
   localparam int FILL_ITEMS = 150;
   localparam longint MAX_COORD = 64'sd2147483647;
   localparam longint MIN_COORD = -64'sd2147483648;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
      logic                 last;
   } cam_point_type;

   logic        clock;
   logic        reset;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   logic          point_valid = 1'b0;
   cam_point_type offered = '0;
   logic          take_ready = 1'b0;
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;
   int            kept_count = 0;
   int            hold_left = 0;
   bit            hold_done = 1'b0;
   int            mismatches = 0;

   logic signed [15:0]   rot_w_cfg = 16'sd16384;
   logic signed [15:0]   rot_x_cfg = '0;
   logic signed [15:0]   rot_y_cfg = '0;
   logic signed [15:0]   rot_z_cfg = '0;
   logic signed [CW-1:0] shift_x_cfg = '0;
   logic signed [CW-1:0] shift_y_cfg = '0;
   logic signed [CW-1:0] shift_z_cfg = '0;
   logic [CW-2:0]        box_side_cfg = 31'd16384;

   cam_point_type pending_points[$];
   cam_point_type kept_points[$];

   rtcb_point_if point_bus ();
   rtcb_kept_if  kept_bus ();

   assign point_bus.valid     = point_valid;
   assign point_bus.point_x   = offered.x;
   assign point_bus.point_y   = offered.y;
   assign point_bus.point_z   = offered.z;
   assign point_bus.cloud_end = offered.last;
   assign kept_bus.ready      = take_ready;

   rigid_transform_crop_box_filter dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (point_bus),
      .rsp_ch  (kept_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

   // Exact test of the moved point against the box, at scale 2^(2F).
   function automatic bit in_crop_box(input cam_point_type p);
      logic signed [127:0] qw, qi, qj, qk, one, px, py, pz, lim, rx, ry, rz;
      logic signed [127:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
      logic signed [127:0] tx, ty, tz, z_floor;
      qw = rot_w_cfg;
      qi = rot_x_cfg;
      qj = rot_y_cfg;
      qk = rot_z_cfg;
      px = p.x;
      py = p.y;
      pz = p.z;
      tx = shift_x_cfg;
      ty = shift_y_cfg;
      tz = shift_z_cfg;
      one = 128'sd1 << (2 * QF);
      m00 = one - 2 * (qj * qj + qk * qk);
      m01 = 2 * (qi * qj - qw * qk);
      m02 = 2 * (qi * qk + qw * qj);
      m10 = 2 * (qi * qj + qw * qk);
      m11 = one - 2 * (qi * qi + qk * qk);
      m12 = 2 * (qj * qk - qw * qi);
      m20 = 2 * (qi * qk - qw * qj);
      m21 = 2 * (qj * qk + qw * qi);
      m22 = one - 2 * (qi * qi + qj * qj);
      rx = m00 * px + m01 * py + m02 * pz + tx * one;
      ry = m10 * px + m11 * py + m12 * pz + ty * one;
      rz = m20 * px + m21 * py + m22 * pz + tz * one;
      lim = box_side_cfg;
      lim = lim * one;
      z_floor = -(128'sd1 << (16 + 2 * QF));
      return (-lim <= 2 * rx) && (2 * rx <= lim) && (-lim <= 2 * ry) && (2 * ry <= lim)
             && (rz <= lim) && (50 * rz >= z_floor);
   endfunction

   function automatic longint spread(input longint span);
      return longint'($urandom_range(32'(2 * span))) - span;
   endfunction

   function automatic int any_quat_part();
      return int'($urandom_range(32768)) - 16384;
   endfunction

   task automatic write_csr(input rtcb_pkg::csr_index_type idx, input logic [31:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         rtcb_pkg::CSR_ROT_W: rot_w_cfg = data[15:0];
         rtcb_pkg::CSR_ROT_X: rot_x_cfg = data[15:0];
         rtcb_pkg::CSR_ROT_Y: rot_y_cfg = data[15:0];
         rtcb_pkg::CSR_ROT_Z: rot_z_cfg = data[15:0];
         rtcb_pkg::CSR_SHIFT_X: shift_x_cfg = data;
         rtcb_pkg::CSR_SHIFT_Y: shift_y_cfg = data;
         rtcb_pkg::CSR_SHIFT_Z: shift_z_cfg = data;
         rtcb_pkg::CSR_BOX_SIDE: box_side_cfg = data[30:0];
      endcase
   endtask

   // Stray bits above the width of the rotation and box-side registers are set at random.
   task automatic load_config(input int qw, input int qx, input int qy, input int qz,
                              input longint tx, input longint ty, input longint tz,
                              input longint len);
      write_csr(rtcb_pkg::CSR_ROT_W, {16'($urandom), 16'(qw)});
      write_csr(rtcb_pkg::CSR_ROT_X, {16'($urandom), 16'(qx)});
      write_csr(rtcb_pkg::CSR_ROT_Y, {16'($urandom), 16'(qy)});
      write_csr(rtcb_pkg::CSR_ROT_Z, {16'($urandom), 16'(qz)});
      write_csr(rtcb_pkg::CSR_SHIFT_X, 32'(tx));
      write_csr(rtcb_pkg::CSR_SHIFT_Y, 32'(ty));
      write_csr(rtcb_pkg::CSR_SHIFT_Z, 32'(tz));
      write_csr(rtcb_pkg::CSR_BOX_SIDE, {1'($urandom), 31'(len)});
   endtask

   task automatic push_point(input longint x, input longint y, input longint z,
                             input bit last);
      cam_point_type p;
      p.x = CW'(x);
      p.y = CW'(y);
      p.z = CW'(z);
      p.last = last;
      pending_points = {pending_points, p};
   endtask

   task automatic wait_quiet();
      while (pending_points.size() != 0 || point_valid || kept_points.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         point_valid <= 1'b0;
      end else begin
         if (point_valid && point_bus.ready && in_crop_box(offered))
            kept_points = {kept_points, offered};
         if (!point_valid || point_bus.ready) begin
            if (pending_points.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered <= pending_points.pop_front();
               point_valid <= 1'b1;
            end else begin
               point_valid <= 1'b0;
            end
         end
      end
   end

   // The long hold-off is started once, while plenty of items are still waiting.
   always @(posedge clock) begin
      if (reset) begin
         take_ready <= 1'b0;
      end else if (hold_left != 0) begin
         take_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && kept_count >= 60 && pending_points.size() > 60) begin
         hold_done <= 1'b1;
         hold_left <= LONG_HOLD_CYCLES;
         take_ready <= 1'b0;
      end else begin
         take_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cam_point_type want;
      cam_point_type got;
      if (!reset && kept_bus.valid && kept_bus.ready) begin
         got.x = kept_bus.kept_x;
         got.y = kept_bus.kept_y;
         got.z = kept_bus.kept_z;
         got.last = kept_bus.kept_end;
         kept_count <= kept_count + 1;
         if (kept_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected kept item: x=%0d y=%0d z=%0d end=%0b",
                        got.x, got.y, got.z, got.last);
         end else begin
            want = kept_points.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.z !== want.z
                || got.last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Kept item mismatch: want %0d %0d %0d %0b, got %0d %0d %0d %0b",
                           want.x, want.y, want.z, want.last,
                           got.x, got.y, got.z, got.last);
            end
         end
      end
   end

   initial begin
      int unit_quat[10][4];
      int qw, qx, qy, qz, pick, n, phase, total;
      longint tx, ty, tz, len, span, cx, cy, cz;
      unit_quat = '{'{16384, 0, 0, 0}, '{-16384, 0, 0, 0}, '{11585, 11585, 0, 0},
                    '{11585, 0, 11585, 0}, '{11585, 0, 0, 11585}, '{0, 16384, 0, 0},
                    '{0, 0, 16384, 0}, '{0, 0, 0, -16384}, '{8192, 8192, 8192, 8192},
                    '{8192, -8192, 8192, -8192}};
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Box edges under the settings left by reset: identity, no shift, side 0.25 m.
      push_point(8192, 0, 0, 0);
      push_point(8193, 0, 0, 0);
      push_point(-8192, 0, 0, 1);
      push_point(-8193, 0, 0, 0);
      push_point(0, 8192, 0, 0);
      push_point(0, -8193, 0, 0);
      push_point(0, 0, 16384, 0);
      push_point(0, 0, 16385, 0);
      push_point(0, 0, -1310, 0);
      push_point(0, 0, -1311, 1);
      push_point(9000, 0, 0, 1);
      push_point(0, 0, 0, 1);
      push_point(MIN_COORD, MAX_COORD, MIN_COORD, 1);
      push_point(MAX_COORD, MIN_COORD, MAX_COORD, 0);
      wait_quiet();

      // All-zero quaternion with extreme shifts and the widest box.
      load_config(0, 0, 0, 0, MAX_COORD, MIN_COORD, 0, MAX_COORD);
      push_point(MIN_COORD, MAX_COORD, 0, 1);
      push_point(MIN_COORD, MAX_COORD, MAX_COORD, 0);
      push_point(0, 0, 0, 0);
      push_point(MAX_COORD, MAX_COORD, MIN_COORD, 1);
      wait_quiet();

      // A box of side zero keeps only points that land on its axis.
      load_config(-16384, 0, 0, 0, 0, 0, 0, 0);
      push_point(0, 0, 0, 1);
      push_point(0, 0, -1310, 0);
      push_point(1, 0, 0, 1);
      push_point(0, 0, 1, 0);
      wait_quiet();

      // Every point is kept here, so the long hold-off fills the block.
      load_config(16384, 0, 0, 0, 0, 0, 0, 16384);
      repeat (FILL_ITEMS) push_point(0, 0, 0, $urandom_range(1));
      wait_quiet();

      total = 0;
      phase = 0;
      while (total < RANDOM_ITEMS) begin
         pick = $urandom_range(9);
         if (pick < 5) begin
            n = $urandom_range(9);
            qw = unit_quat[n][0];
            qx = unit_quat[n][1];
            qy = unit_quat[n][2];
            qz = unit_quat[n][3];
         end else if (pick < 7) begin
            qw = any_quat_part();
            qx = 0;
            qy = 0;
            qz = 0;
         end else if (pick == 7) begin
            qw = 0;
            qx = 0;
            qy = 0;
            qz = 0;
         end else begin
            qw = any_quat_part();
            qx = any_quat_part();
            qy = any_quat_part();
            qz = any_quat_part();
         end
         pick = $urandom_range(9);
         if (pick == 0)
            len = 0;
         else if (pick == 1)
            len = MAX_COORD;
         else if (pick == 2)
            len = $urandom_range(4095);
         else
            len = $urandom_range(1 << 22, 1 << 12);
         span = (len > (64'sd1 << 30)) ? (64'sd1 << 30) : ((len < 16) ? 16 : len);
         if (qx == 0 && qy == 0 && qz == 0) begin
            tx = longint'(int'($urandom));
            ty = longint'(int'($urandom));
            tz = longint'(int'($urandom));
            cx = -tx;
            cy = -ty;
            cz = -tz;
         end else begin
            tx = spread(span / 4);
            ty = spread(span / 4);
            tz = spread(span / 4);
            cx = 0;
            cy = 0;
            cz = 0;
         end
         load_config(qw, qx, qy, qz, tx, ty, tz, len);
         case (phase % 4)
            0: begin
               send_idle_pct <= 0;
               recv_stall_pct <= 0;
            end
            1: begin
               send_idle_pct <= 64;
               recv_stall_pct <= 0;
            end
            2: begin
               send_idle_pct <= 0;
               recv_stall_pct <= 64;
            end
            default: begin
               send_idle_pct <= 16;
               recv_stall_pct <= 16;
            end
         endcase
         @(posedge clock);
         n = $urandom_range(150, 100);
         repeat (n) begin
            if ($urandom_range(4) != 0)
               push_point(cx + spread(span), cy + spread(span), cz + spread(span),
                          $urandom_range(7) == 0);
            else
               push_point(longint'(int'($urandom)), longint'(int'($urandom)),
                          longint'(int'($urandom)), $urandom_range(1));
         end
         total += n;
         phase++;
         wait_quiet();
      end

      if (mismatches == 0 && kept_points.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
